/* hw/rtl/power_of_two_frame_allocator_unit_macros.svh */
// Assertion macros used by the frame allocator checker.
`ifndef POWER_OF_TWO_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define POWER_OF_TWO_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pfa_pkg.sv */
// Shared types, codes and helpers of the frame allocator.
package pfa_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OOM       = 2'd1;
    localparam logic [1:0] STAT_BAD_COUNT = 2'd2;

    localparam int MAX_TRIAL = 16;
    localparam logic [2:0] MAX_CLASS = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_FREE      = 7'b0000010,
        ST_FREE_LAST = 7'b0000100,
        ST_CHECK     = 7'b0001000,
        ST_SCAN      = 7'b0010000,
        ST_FILL      = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_sts_t;

    // Largest class c, at most four, whose block size 2^c fits in the trial size.
    function automatic logic [2:0] class_of(input logic [4:0] trial);
        logic [2:0] c;
        c = 3'd0;
        for (int i = 1; i <= 4; i++) begin
            if (trial >= (5'd1 << i)) begin
                c = 3'(i);
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/power_of_two_frame_allocator_unit.sv */
// Top level of the power-of-two frame allocator with its request sequencer.
// A free request reads the owner memory one frame per cycle.
// An allocate request tries one trial size after another and fills each block it finds page by page;
// the frame walker visits one frame per cycle to find each block head.
// A bad page count goes straight to the result. One request is in work at a time.
// Reset marks every frame free; the owner memory is not cleared and needs no clearing pass.
module power_of_two_frame_allocator_unit #(
    parameter int NUM_FRAMES = 16,
    parameter int ID_BITS    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[0], process_id[8:1], page_count[13:9], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], pages_placed[6:2], free_frames[11:7], zero fill
);

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int KW = $clog2(NUM_FRAMES + 1);
    localparam int PW = (KW > 5) ? KW : 5;

    pfa_pkg::state_t state_reg, state_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [4:0]         rem_reg, rem_next;
    logic [4:0]         trial_reg, trial_next;
    logic [PW-1:0]      placed_reg, placed_next;
    logic [KW-1:0]      free_cnt_reg, free_cnt_next;
    logic [1:0]         status_reg, status_next;
    logic [IW-1:0]      fill_ptr_reg, fill_ptr_next;
    logic [4:0]         fill_n_reg, fill_n_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               cmp_vld_reg;
    logic [IW-1:0]      cmp_idx_reg;
    logic               m_valid_reg;
    logic [15:0]        m_data_reg;

    logic                  s_accept;
    logic                  in_cmd;
    logic [4:0]            in_pages;
    logic [ID_BITS-1:0]    in_id;
    logic [2:0]            cls;
    logic [4:0]            blk_size;
    logic [4:0]            trial_adv;
    logic                  scan_start;
    pfa_pkg::scan_sts_t    scan_sts;
    logic [IW-1:0]         scan_head;
    logic [NUM_FRAMES-1:0] used;
    logic [ID_BITS-1:0]    rd_owner;
    logic                  cmp_hit;
    logic                  set_en;
    logic                  out_load;
    logic [PW-1:0]         free_x;

    assign s_tready = (state_reg == pfa_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_cmd   = s_tdata[0];
    assign in_pages = s_tdata[13:9];

    always_comb begin
        in_id = '0;
        for (int b = 0; b < ID_BITS && b < 8; b++) begin
            in_id[b] = s_tdata[1 + b];
        end
    end

    assign cls       = pfa_pkg::class_of(trial_reg);
    assign blk_size  = 5'd1 << cls;
    assign trial_adv = (int'(trial_reg) >= pfa_pkg::MAX_TRIAL) ? 5'd1 : trial_reg + 5'd1;
    assign cmp_hit   = cmp_vld_reg && used[cmp_idx_reg] && (rd_owner == id_reg);
    assign set_en    = (state_reg == pfa_pkg::ST_FILL);
    assign out_load  = (state_reg == pfa_pkg::ST_DONE) && (!m_valid_reg || m_tready);
    assign free_x    = PW'(free_cnt_reg);

    pfa_frame_store #(
        .NUM_FRAMES(NUM_FRAMES),
        .ID_BITS   (ID_BITS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .set_en   (set_en),
        .set_idx  (fill_ptr_reg),
        .set_owner(id_reg),
        .clr_en   (cmp_hit),
        .clr_idx  (cmp_idx_reg),
        .rd_idx   (free_idx_reg),
        .rd_owner (rd_owner),
        .used     (used)
    );

    pfa_head_scan #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_scan (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (scan_start),
        .cls    (cls),
        .used   (used),
        .sts    (scan_sts),
        .head   (scan_head)
    );

    always_comb begin
        state_next    = state_reg;
        id_next       = id_reg;
        rem_next      = rem_reg;
        trial_next    = trial_reg;
        placed_next   = placed_reg;
        free_cnt_next = free_cnt_reg;
        status_next   = status_reg;
        fill_ptr_next = fill_ptr_reg;
        fill_n_next   = fill_n_reg;
        free_idx_next = free_idx_reg;
        scan_start    = 1'b0;

        if (cmp_hit) begin
            placed_next   = placed_reg + PW'(1);
            free_cnt_next = free_cnt_reg + KW'(1);
        end

        unique case (state_reg)
            pfa_pkg::ST_IDLE: begin
                if (s_accept) begin
                    id_next       = in_id;
                    rem_next      = in_pages;
                    trial_next    = in_pages;
                    placed_next   = '0;
                    status_next   = pfa_pkg::STAT_OK;
                    free_idx_next = '0;
                    if (in_cmd == pfa_pkg::CMD_FREE) begin
                        state_next = pfa_pkg::ST_FREE;
                    end else if (int'(in_pages) > NUM_FRAMES ||
                                 int'(in_pages) > pfa_pkg::MAX_TRIAL) begin
                        status_next = pfa_pkg::STAT_BAD_COUNT;
                        state_next  = pfa_pkg::ST_DONE;
                    end else begin
                        state_next = pfa_pkg::ST_CHECK;
                    end
                end
            end
            pfa_pkg::ST_FREE: begin
                free_idx_next = free_idx_reg + IW'(1);
                if (free_idx_reg == IW'(NUM_FRAMES - 1)) begin
                    state_next = pfa_pkg::ST_FREE_LAST;
                end
            end
            pfa_pkg::ST_FREE_LAST: begin
                state_next = pfa_pkg::ST_DONE;
            end
            pfa_pkg::ST_CHECK: begin
                if (rem_reg == 5'd0) begin
                    state_next = pfa_pkg::ST_DONE;
                end else if (free_cnt_reg == '0) begin
                    status_next = pfa_pkg::STAT_OOM;
                    state_next  = pfa_pkg::ST_DONE;
                end else begin
                    scan_start = 1'b1;
                    state_next = pfa_pkg::ST_SCAN;
                end
            end
            pfa_pkg::ST_SCAN: begin
                if (scan_sts.done) begin
                    if (scan_sts.found) begin
                        fill_ptr_next = scan_head;
                        fill_n_next   = (blk_size > rem_reg) ? rem_reg : blk_size;
                        state_next    = pfa_pkg::ST_FILL;
                    end else begin
                        trial_next = trial_adv;
                        state_next = pfa_pkg::ST_CHECK;
                    end
                end
            end
            pfa_pkg::ST_FILL: begin
                fill_ptr_next = fill_ptr_reg + IW'(1);
                fill_n_next   = fill_n_reg - 5'd1;
                rem_next      = rem_reg - 5'd1;
                placed_next   = placed_reg + PW'(1);
                free_cnt_next = free_cnt_reg - KW'(1);
                if (fill_n_reg == 5'd1) begin
                    trial_next = trial_adv;
                    state_next = pfa_pkg::ST_CHECK;
                end
            end
            pfa_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pfa_pkg::ST_IDLE;
            free_cnt_reg <= KW'(NUM_FRAMES);
            cmp_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            cmp_vld_reg  <= (state_reg == pfa_pkg::ST_FREE);
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        rem_reg      <= rem_next;
        trial_reg    <= trial_next;
        placed_reg   <= placed_next;
        status_reg   <= status_next;
        fill_ptr_reg <= fill_ptr_next;
        fill_n_reg   <= fill_n_next;
        free_idx_reg <= free_idx_next;
        cmp_idx_reg  <= free_idx_reg;
        if (out_load) begin
            m_data_reg <= {4'b0000, free_x[4:0], placed_reg[4:0], status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* hw/rtl/pfa_frame_store.sv */
// Frame store: used flags in flip-flops and an owner memory with registered read.
module pfa_frame_store #(
    parameter int NUM_FRAMES = 16,
    parameter int ID_BITS    = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          set_en,
    input  logic [$clog2(NUM_FRAMES)-1:0] set_idx,
    input  logic [ID_BITS-1:0]            set_owner,
    input  logic                          clr_en,
    input  logic [$clog2(NUM_FRAMES)-1:0] clr_idx,
    input  logic [$clog2(NUM_FRAMES)-1:0] rd_idx,
    output logic [ID_BITS-1:0]            rd_owner,
    output logic [NUM_FRAMES-1:0]         used
);

    logic [NUM_FRAMES-1:0] used_reg;
    logic [ID_BITS-1:0]    owner_mem [NUM_FRAMES];
    logic [ID_BITS-1:0]    rd_owner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            if (set_en) begin
                used_reg[set_idx] <= 1'b1;
            end
            if (clr_en) begin
                used_reg[clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (set_en) begin
            owner_mem[set_idx] <= set_owner;
        end
        rd_owner_reg <= owner_mem[rd_idx];
    end

    assign used     = used_reg;
    assign rd_owner = rd_owner_reg;

endmodule

/* hw/rtl/pfa_head_scan.sv */
// Frame walker that finds the lowest block of one size class, one frame per cycle.
module pfa_head_scan #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [2:0]                    cls,
    input  logic [NUM_FRAMES-1:0]         used,
    output pfa_pkg::scan_sts_t            sts,
    output logic [$clog2(NUM_FRAMES)-1:0] head
);

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int KW = $clog2(NUM_FRAMES + 1);
    localparam int XW = (KW > 5) ? KW : 5;

    logic               busy_reg;
    logic [KW-1:0]      k_reg;
    logic [IW-1:0]      run_start_reg;
    logic [KW-1:0]      run_len_reg;
    pfa_pkg::scan_sts_t sts_reg;
    logic [IW-1:0]      head_reg;

    logic          at_end;
    logic [IW-1:0] idx;
    logic          cur_free;
    logic [XW-1:0] len_x;
    logic [XW-1:0] off;
    logic          hit_raw;
    logic          hit;
    logic [IW-1:0] hit_head;

    always_comb begin
        at_end   = (k_reg == KW'(NUM_FRAMES));
        idx      = at_end ? '0 : k_reg[IW-1:0];
        cur_free = !at_end && !used[idx];
        len_x    = XW'(run_len_reg);
        if (cls == pfa_pkg::MAX_CLASS) begin
            hit_raw = (len_x >= XW'(16));
            off     = '0;
        end else begin
            hit_raw = len_x[cls[1:0]];
            off     = len_x & ~((XW'(2) << cls) - XW'(1));
        end
        hit      = (run_len_reg != '0) && hit_raw;
        hit_head = IW'(XW'(run_start_reg) + off);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sts_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg      <= 1'b1;
                k_reg         <= '0;
                run_len_reg   <= '0;
                sts_reg.done  <= 1'b0;
                sts_reg.found <= 1'b0;
            end else if (busy_reg) begin
                if (cur_free) begin
                    if (run_len_reg == '0) begin
                        run_start_reg <= k_reg[IW-1:0];
                    end
                    run_len_reg <= run_len_reg + KW'(1);
                    k_reg       <= k_reg + KW'(1);
                end else if (hit) begin
                    busy_reg      <= 1'b0;
                    sts_reg.done  <= 1'b1;
                    sts_reg.found <= 1'b1;
                    head_reg      <= hit_head;
                end else if (at_end) begin
                    busy_reg      <= 1'b0;
                    sts_reg.done  <= 1'b1;
                    sts_reg.found <= 1'b0;
                end else begin
                    run_len_reg <= '0;
                    k_reg       <= k_reg + KW'(1);
                end
            end else begin
                sts_reg.done <= 1'b0;
            end
        end
    end

    assign sts  = sts_reg;
    assign head = head_reg;

endmodule

/* hw/rtl/pfa_checker.sv */
// Port-level checker for the frame allocator and its bind to the top level.
`include "power_of_two_frame_allocator_unit_macros.svh"

module pfa_checker #(
    parameter int NUM_FRAMES = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic s_acc;
    logic m_stall;

    assign s_acc   = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    `PFA_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_tdata), "Stalled result word changed.")
    `PFA_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_tready, "Request word accepted while busy.")
    `PFA_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[1:0] != 2'd3, "Undefined status code.")
    `PFA_ASSERT_NOW(a_bad_count_none, m_tvalid && m_tdata[1:0] == 2'd2, m_tdata[6:2] == 5'd0, "Rejected request placed pages.")
    `PFA_ASSERT_NOW(a_free_bound, m_tvalid, NUM_FRAMES >= 32 || int'(m_tdata[11:7]) <= NUM_FRAMES, "Free count above frame total.")

endmodule

bind power_of_two_frame_allocator_unit pfa_checker #(
    .NUM_FRAMES(NUM_FRAMES)
) u_pfa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
